// ===== src/trs_mmb_pkg.sv =====
// Shared types, constants and arithmetic helpers for the TRS model matrix builder.
package trs_mmb_pkg;

  // fixed point format of the pose and result words
  localparam int FRAC_BITS = 16;

  typedef logic signed [31:0] q16_t;

  // quadrant of a reduced angle
  typedef enum logic [1:0] {
    QD_0   = 2'd0,
    QD_90  = 2'd1,
    QD_180 = 2'd2,
    QD_270 = 2'd3
  } quad_t;

  // angle range reduction
  localparam longint unsigned FULL_DEG = 64'd360 << FRAC_BITS;
  localparam longint unsigned QTR_DEG  = 64'd90 << FRAC_BITS;
  localparam longint unsigned HALF_DEG = 64'd180 << FRAC_BITS;
  localparam longint unsigned TQTR_DEG = 64'd270 << FRAC_BITS;
  localparam longint unsigned OCT_DEG  = 64'd45 << FRAC_BITS;
  localparam int RW  = $clog2(FULL_DEG);
  localparam int RQW = (RW >= 32) ? 1 : 33 - RW;
  localparam int RED_S = 30 + RW;
  localparam longint unsigned RED_M = (64'd1 << RED_S) / FULL_DEG;
  // unsigned offset (2^31) folded back after reduction
  localparam longint unsigned RED_OFFS = (64'd1 << 31) % FULL_DEG;
  localparam int UW = FRAC_BITS + 6;

  // degrees to radians, Q32
  localparam longint unsigned K_DEG = 64'd74961321;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  // exact reciprocals for the series divisors, valid for 31-bit dividends
  localparam int DIV_S_SH [4] = '{38, 37, 36, 34};
  localparam longint unsigned DIV_S_M [4] = '{
    ((64'd1 << 38) + 64'd71) / 64'd72,
    ((64'd1 << 37) + 64'd41) / 64'd42,
    ((64'd1 << 36) + 64'd19) / 64'd20,
    ((64'd1 << 34) + 64'd5) / 64'd6
  };
  localparam int DIV_C_SH [4] = '{38, 37, 36, 35};
  localparam longint unsigned DIV_C_M [4] = '{
    ((64'd1 << 38) + 64'd89) / 64'd90,
    ((64'd1 << 37) + 64'd55) / 64'd56,
    ((64'd1 << 36) + 64'd29) / 64'd30,
    ((64'd1 << 35) + 64'd11) / 64'd12
  };

  // unsigned Q1.30 product, rounded half up
  function automatic logic [31:0] umul30(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = 64'(a) * 64'(b) + (64'd1 << 29);
    return p[61:30];
  endfunction

  // signed Q1.30 product, rounded half up
  function automatic logic signed [33:0] smul30(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b + (68'sd1 <<< 29);
    return p[63:30];
  endfunction

  // floor(n / d) through a precomputed reciprocal m and shift sh
  function automatic logic [30:0] div_const(input logic [30:0] n, input logic [31:0] m,
                                            input int sh);
    logic [63:0] p;
    p = 64'(n) * 64'(m);
    return 31'(p >> sh);
  endfunction

  // clamp to the signed 32-bit range
  function automatic q16_t sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fff_ffff;
    end
    if (v < -66'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== src/trs_mmb_if.sv =====
// Handshake channels for pose words in and matrix row words out.
interface trs_mmb_in_if;
  logic                valid;
  logic                ready;
  trs_mmb_pkg::q16_t   pos_x;
  trs_mmb_pkg::q16_t   pos_y;
  trs_mmb_pkg::q16_t   pos_z;
  trs_mmb_pkg::q16_t   angle_x;
  trs_mmb_pkg::q16_t   angle_y;
  trs_mmb_pkg::q16_t   angle_z;
  trs_mmb_pkg::q16_t   scale_x;
  trs_mmb_pkg::q16_t   scale_y;
  trs_mmb_pkg::q16_t   scale_z;

  modport source (output valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                  scale_x, scale_y, scale_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, angle_x, angle_y, angle_z,
                scale_x, scale_y, scale_z, output ready);
endinterface

interface trs_mmb_out_if;
  logic                valid;
  logic                ready;
  logic [1:0]          row_index;
  trs_mmb_pkg::q16_t   m_col0;
  trs_mmb_pkg::q16_t   m_col1;
  trs_mmb_pkg::q16_t   m_col2;
  trs_mmb_pkg::q16_t   m_col3;
  trs_mmb_pkg::q16_t   r_col0;
  trs_mmb_pkg::q16_t   r_col1;
  trs_mmb_pkg::q16_t   r_col2;
  logic                last;

  modport source (output valid, row_index, m_col0, m_col1, m_col2, m_col3,
                  r_col0, r_col1, r_col2, last, input ready);
  modport sink (input valid, row_index, m_col0, m_col1, m_col2, m_col3,
                r_col0, r_col1, r_col2, last, output ready);
endinterface

// ===== src/trs_model_matrix_builder.sv =====
// Pipeline: 20 pipeline stages, the first loaded at the edge that accepts a pose word,
// then the row output register, which offers the first row word of that pose.
// Flow: the output register sends three row words per pose; a pose enters the pipeline
// only while it advances, and it stalls while the last stage holds a word not yet taken.
// Reset: synchronous, active low; clears stage valid bits and the row output state.
module trs_model_matrix_builder (
  input  logic          clk,
  input  logic          rst_n,
  trs_mmb_in_if.sink    in_ch,
  trs_mmb_out_if.source out_ch
);

  localparam int NST = 20;

  // stage valid bits and global advance
  logic           vld_r [1:NST];
  logic           en;
  logic           ser_load;

  // pose carried alongside the math
  trs_mmb_pkg::q16_t pos_p [1:NST][3];
  trs_mmb_pkg::q16_t scl_p [1:19][3];

  // angle lanes: x, y, z
  logic [31:0]           ang_u   [3];
  logic [31:0]           au1_r   [3];
  logic [trs_mmb_pkg::RQW-1:0] qe1_r [3];
  logic [31:0]           rem2_r  [3];
  logic [trs_mmb_pkg::RW-1:0] red3_r [3];
  logic [trs_mmb_pkg::RW-1:0] red3_nxt [3];
  logic [trs_mmb_pkg::RW-1:0] t4_r [3];
  logic [trs_mmb_pkg::RW-1:0] t4_nxt [3];
  trs_mmb_pkg::quad_t    qd4_nxt [3];
  logic [trs_mmb_pkg::UW-1:0] u5_r [3];
  logic [trs_mmb_pkg::UW-1:0] u5_nxt [3];
  logic [30:0]           x6_nxt  [3];
  trs_mmb_pkg::quad_t    qd_p    [3][4:15];
  logic                  sw_p    [3][5:15];
  logic [30:0]           x_p     [3][6:14];
  logic [31:0]           x2_p    [3][7:14];
  logic [31:0]           cs_r    [3][8:15];
  logic [31:0]           cc_r    [3][8:15];
  logic signed [33:0]    sin_r   [3];
  logic signed [33:0]    cos_r   [3];
  logic signed [33:0]    sin_nxt [3];
  logic signed [33:0]    cos_nxt [3];

  // rotation stages
  logic signed [33:0]    p17_r   [10];
  logic signed [33:0]    sx17_r, cx17_r, sy17_r;
  logic signed [33:0]    a18_r   [9];
  logic signed [33:0]    b18_r   [9];
  logic signed [33:0]    rot19_r [9];
  trs_mmb_pkg::q16_t     m20_r   [3][3];
  trs_mmb_pkg::q16_t     r20_r   [3][3];
  trs_mmb_pkg::q16_t     m20_nxt [3][3];
  trs_mmb_pkg::q16_t     r20_nxt [3][3];

  // row output register
  logic                  busy_r;
  logic [1:0]            cnt_r;
  trs_mmb_pkg::q16_t     ser_m_r [3][3];
  trs_mmb_pkg::q16_t     ser_r_r [3][3];
  trs_mmb_pkg::q16_t     ser_pos_r [3];

  // pipeline advances unless the last stage holds a word the output can't take
  assign ser_load = vld_r[NST] && (!busy_r || (out_ch.ready && cnt_r == 2'd2));
  assign en       = !vld_r[NST] || ser_load;
  assign in_ch.ready = en && rst_n;

  // angles offset to unsigned for reduction
  assign ang_u[0] = {~in_ch.angle_x[31], in_ch.angle_x[30:0]};
  assign ang_u[1] = {~in_ch.angle_y[31], in_ch.angle_y[30:0]};
  assign ang_u[2] = {~in_ch.angle_z[31], in_ch.angle_z[30:0]};

  // reduction fix-up, quadrant split, fold, radians
  always_comb begin
    logic [63:0] tmp;
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] xp;
    for (int l = 0; l < 3; l++) begin
      tmp = 64'(rem2_r[l]);
      if (tmp >= trs_mmb_pkg::FULL_DEG) begin
        tmp = tmp - trs_mmb_pkg::FULL_DEG;
      end
      if (tmp >= trs_mmb_pkg::RED_OFFS) begin
        red3_nxt[l] = trs_mmb_pkg::RW'(tmp - trs_mmb_pkg::RED_OFFS);
      end else begin
        red3_nxt[l] = trs_mmb_pkg::RW'(tmp + trs_mmb_pkg::FULL_DEG - trs_mmb_pkg::RED_OFFS);
      end

      r = 64'(red3_r[l]);
      if (r >= trs_mmb_pkg::TQTR_DEG) begin
        qd4_nxt[l] = trs_mmb_pkg::QD_270;
        t4_nxt[l]  = trs_mmb_pkg::RW'(r - trs_mmb_pkg::TQTR_DEG);
      end else if (r >= trs_mmb_pkg::HALF_DEG) begin
        qd4_nxt[l] = trs_mmb_pkg::QD_180;
        t4_nxt[l]  = trs_mmb_pkg::RW'(r - trs_mmb_pkg::HALF_DEG);
      end else if (r >= trs_mmb_pkg::QTR_DEG) begin
        qd4_nxt[l] = trs_mmb_pkg::QD_90;
        t4_nxt[l]  = trs_mmb_pkg::RW'(r - trs_mmb_pkg::QTR_DEG);
      end else begin
        qd4_nxt[l] = trs_mmb_pkg::QD_0;
        t4_nxt[l]  = trs_mmb_pkg::RW'(r);
      end

      t = 64'(t4_r[l]);
      if (t > trs_mmb_pkg::OCT_DEG) begin
        u5_nxt[l] = trs_mmb_pkg::UW'(trs_mmb_pkg::QTR_DEG - t);
      end else begin
        u5_nxt[l] = trs_mmb_pkg::UW'(t);
      end

      xp = 64'(u5_r[l]) * trs_mmb_pkg::K_DEG + (64'd1 << (trs_mmb_pkg::FRAC_BITS + 1));
      x6_nxt[l] = 31'(xp >> (trs_mmb_pkg::FRAC_BITS + 2));
    end
  end

  // sign and quadrant map of the series results
  always_comb begin
    logic signed [33:0] s;
    logic signed [33:0] c;
    logic signed [33:0] tmp;
    for (int l = 0; l < 3; l++) begin
      s = $signed({2'b00, cs_r[l][15]});
      c = $signed({2'b00, trs_mmb_pkg::ONE_Q30}) - $signed({3'b000, cc_r[l][15][31:1]});
      if (sw_p[l][15]) begin
        tmp = s;
        s   = c;
        c   = tmp;
      end
      case (qd_p[l][15])
        trs_mmb_pkg::QD_0: begin
          sin_nxt[l] = s;
          cos_nxt[l] = c;
        end
        trs_mmb_pkg::QD_90: begin
          sin_nxt[l] = c;
          cos_nxt[l] = -s;
        end
        trs_mmb_pkg::QD_180: begin
          sin_nxt[l] = -s;
          cos_nxt[l] = -c;
        end
        default: begin
          sin_nxt[l] = -c;
          cos_nxt[l] = s;
        end
      endcase
    end
  end

  // scale the rotation for the matrix words; round and saturate scaled and unscaled words
  always_comb begin
    logic signed [65:0] pm;
    logic signed [65:0] pr;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pm = rot19_r[3*i+j] * scl_p[19][j];
        pm = (pm + (66'sd1 <<< 29)) >>> 30;
        pr = 66'(rot19_r[3*i+j]);
        pr = (pr + (66'sd1 <<< (29 - trs_mmb_pkg::FRAC_BITS)))
             >>> (30 - trs_mmb_pkg::FRAC_BITS);
        m20_nxt[i][j] = trs_mmb_pkg::sat32(pm);
        r20_nxt[i][j] = trs_mmb_pkg::sat32(pr);
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= NST; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (en) begin
      vld_r[1] <= in_ch.valid;
      for (int s = 2; s <= NST; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  // pipeline datapath
  always_ff @(posedge clk) begin
    if (en) begin
      // pose carry
      pos_p[1][0] <= in_ch.pos_x;
      pos_p[1][1] <= in_ch.pos_y;
      pos_p[1][2] <= in_ch.pos_z;
      scl_p[1][0] <= in_ch.scale_x;
      scl_p[1][1] <= in_ch.scale_y;
      scl_p[1][2] <= in_ch.scale_z;
      for (int s = 2; s <= NST; s++) begin
        pos_p[s] <= pos_p[s-1];
      end
      for (int s = 2; s <= 19; s++) begin
        scl_p[s] <= scl_p[s-1];
      end

      for (int l = 0; l < 3; l++) begin
        // quotient estimate, remainder, fix-up
        au1_r[l]  <= ang_u[l];
        qe1_r[l]  <= trs_mmb_pkg::RQW'((64'(ang_u[l]) * trs_mmb_pkg::RED_M)
                     >> trs_mmb_pkg::RED_S);
        rem2_r[l] <= 32'(64'(au1_r[l]) - 64'(qe1_r[l]) * trs_mmb_pkg::FULL_DEG);
        red3_r[l] <= red3_nxt[l];
        t4_r[l]   <= t4_nxt[l];
        qd_p[l][4] <= qd4_nxt[l];
        for (int s = 5; s <= 15; s++) begin
          qd_p[l][s] <= qd_p[l][s-1];
        end
        u5_r[l]    <= u5_nxt[l];
        sw_p[l][5] <= 64'(t4_r[l]) > trs_mmb_pkg::OCT_DEG;
        for (int s = 6; s <= 15; s++) begin
          sw_p[l][s] <= sw_p[l][s-1];
        end
        x_p[l][6] <= x6_nxt[l];
        for (int s = 7; s <= 14; s++) begin
          x_p[l][s] <= x_p[l][s-1];
        end
        x2_p[l][7] <= trs_mmb_pkg::umul30({1'b0, x_p[l][6]}, {1'b0, x_p[l][6]});
        for (int s = 8; s <= 14; s++) begin
          x2_p[l][s] <= x2_p[l][s-1];
        end

        // Horner series: divide stage, then multiply stage
        cs_r[l][8] <= 32'(trs_mmb_pkg::div_const(x2_p[l][7][30:0],
                      32'(trs_mmb_pkg::DIV_S_M[0]), trs_mmb_pkg::DIV_S_SH[0]));
        cc_r[l][8] <= 32'(trs_mmb_pkg::div_const(x2_p[l][7][30:0],
                      32'(trs_mmb_pkg::DIV_C_M[0]), trs_mmb_pkg::DIV_C_SH[0]));
        for (int k = 1; k < 4; k++) begin
          cs_r[l][8+2*k] <= 32'(trs_mmb_pkg::div_const(cs_r[l][7+2*k][30:0],
                            32'(trs_mmb_pkg::DIV_S_M[k]), trs_mmb_pkg::DIV_S_SH[k]));
          cc_r[l][8+2*k] <= 32'(trs_mmb_pkg::div_const(cc_r[l][7+2*k][30:0],
                            32'(trs_mmb_pkg::DIV_C_M[k]), trs_mmb_pkg::DIV_C_SH[k]));
        end
        for (int k = 0; k < 3; k++) begin
          cs_r[l][9+2*k] <= trs_mmb_pkg::umul30(x2_p[l][8+2*k],
                            trs_mmb_pkg::ONE_Q30 - cs_r[l][8+2*k]);
          cc_r[l][9+2*k] <= trs_mmb_pkg::umul30(x2_p[l][8+2*k],
                            trs_mmb_pkg::ONE_Q30 - cc_r[l][8+2*k]);
        end
        cs_r[l][15] <= trs_mmb_pkg::umul30({1'b0, x_p[l][14]},
                       trs_mmb_pkg::ONE_Q30 - cs_r[l][14]);
        cc_r[l][15] <= trs_mmb_pkg::umul30(x2_p[l][14],
                       trs_mmb_pkg::ONE_Q30 - cc_r[l][14]);

        sin_r[l] <= sin_nxt[l];
        cos_r[l] <= cos_nxt[l];
      end

      // pair products (lane 0 = x, 1 = y, 2 = z)
      p17_r[0] <= trs_mmb_pkg::smul30(cos_r[2], cos_r[1]);
      p17_r[1] <= trs_mmb_pkg::smul30(cos_r[2], sin_r[1]);
      p17_r[2] <= trs_mmb_pkg::smul30(sin_r[2], cos_r[0]);
      p17_r[3] <= trs_mmb_pkg::smul30(sin_r[2], sin_r[1]);
      p17_r[4] <= trs_mmb_pkg::smul30(cos_r[2], cos_r[0]);
      p17_r[5] <= trs_mmb_pkg::smul30(sin_r[2], cos_r[1]);
      p17_r[6] <= trs_mmb_pkg::smul30(cos_r[1], sin_r[0]);
      p17_r[7] <= trs_mmb_pkg::smul30(cos_r[1], cos_r[0]);
      p17_r[8] <= trs_mmb_pkg::smul30(sin_r[2], sin_r[0]);
      p17_r[9] <= trs_mmb_pkg::smul30(cos_r[2], sin_r[0]);
      sx17_r   <= sin_r[0];
      cx17_r   <= cos_r[0];
      sy17_r   <= sin_r[1];

      // triple products and second terms
      a18_r[0] <= p17_r[0];
      b18_r[0] <= '0;
      a18_r[1] <= trs_mmb_pkg::smul30(p17_r[1], sx17_r);
      b18_r[1] <= -p17_r[2];
      a18_r[2] <= trs_mmb_pkg::smul30(p17_r[1], cx17_r);
      b18_r[2] <= p17_r[8];
      a18_r[3] <= p17_r[5];
      b18_r[3] <= '0;
      a18_r[4] <= trs_mmb_pkg::smul30(p17_r[3], sx17_r);
      b18_r[4] <= p17_r[4];
      a18_r[5] <= trs_mmb_pkg::smul30(p17_r[3], cx17_r);
      b18_r[5] <= -p17_r[9];
      a18_r[6] <= -sy17_r;
      b18_r[6] <= '0;
      a18_r[7] <= p17_r[6];
      b18_r[7] <= '0;
      a18_r[8] <= p17_r[7];
      b18_r[8] <= '0;

      for (int e = 0; e < 9; e++) begin
        rot19_r[e] <= a18_r[e] + b18_r[e];
      end

      m20_r <= m20_nxt;
      r20_r <= r20_nxt;
    end
  end

  // row output control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else if (ser_load) begin
      busy_r <= 1'b1;
      cnt_r  <= 2'd0;
    end else if (busy_r && out_ch.ready) begin
      if (cnt_r == 2'd2) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 2'd1;
      end
    end
  end

  // row output payload
  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_m_r   <= m20_r;
      ser_r_r   <= r20_r;
      ser_pos_r <= pos_p[NST];
    end
  end

  assign out_ch.valid     = busy_r;
  assign out_ch.row_index = cnt_r;
  assign out_ch.m_col0    = ser_m_r[cnt_r][0];
  assign out_ch.m_col1    = ser_m_r[cnt_r][1];
  assign out_ch.m_col2    = ser_m_r[cnt_r][2];
  assign out_ch.m_col3    = ser_pos_r[cnt_r];
  assign out_ch.r_col0    = ser_r_r[cnt_r][0];
  assign out_ch.r_col1    = ser_r_r[cnt_r][1];
  assign out_ch.r_col2    = ser_r_r[cnt_r][2];
  assign out_ch.last      = (cnt_r == 2'd2);

endmodule

// ===== src/trs_mmb_checker.sv =====
// Port-level checks on the row output sequence, bound to the top level.
module trs_mmb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_row_index,
  input logic        out_last,
  input logic [31:0] out_m_col0
);

  // a stalled row word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_index) && $stable(out_m_col0))
    else $error("row word changed while stalled");

  // last marks row 2 and no row index beyond 2
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_row_index != 2'd3 && (out_last == (out_row_index == 2'd2)))
    else $error("bad row index or last flag");

  // rows of one pose follow back to back in order
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && out_row_index == $past(out_row_index) + 2'd1)
    else $error("row sequence broken");

  // reset empties the output
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind trs_model_matrix_builder trs_mmb_checker u_trs_mmb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_row_index (out_ch.row_index),
  .out_last      (out_ch.last),
  .out_m_col0    (out_ch.m_col0)
);
